// ----- rtl/dqnp_pkg.sv -----
// ----------------------------------------------------------------------------
// DNS question name parser package
// Shared constants, parser phase codes and the queue entry type.
// ----------------------------------------------------------------------------
package dqnp_pkg;

  localparam int NAME_LIMIT_DEF  = 255;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int HEADER_BYTES    = 12;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_LEN     = 6'b000010,
    PH_LABEL   = 6'b000100,
    PH_TYPE_HI = 6'b001000,
    PH_TYPE_LO = 6'b010000,
    PH_DONE    = 6'b100000
  } dqnp_phase_t;

  typedef struct packed {
    logic        has_char;
    logic [7:0]  name_char;
    logic        has_sum;
    logic        type_valid;
    logic [15:0] query_type;
    logic [7:0]  name_length;
    logic        name_truncated;
  } dqnp_op_t;

endpackage

// ----- rtl/dqnp_if.sv -----
// ----------------------------------------------------------------------------
// DNS question name parser channels
// Valid/ready channels for message bytes and for parser results.
// ----------------------------------------------------------------------------
interface dqnp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       msg_last;

  modport source (output valid, output msg_byte, output msg_last, input ready);
  modport sink   (input valid, input msg_byte, input msg_last, output ready);
endinterface

interface dqnp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  name_char;
  logic [15:0] query_type;
  logic        type_valid;
  logic [7:0]  name_length;
  logic        name_truncated;
  logic        run_last;

  modport source (output valid, output kind, output name_char, output query_type,
                  output type_valid, output name_length, output name_truncated,
                  output run_last, input ready);
  modport sink   (input valid, input kind, input name_char, input query_type,
                  input type_valid, input name_length, input name_truncated,
                  input run_last, output ready);
endinterface

// ----- rtl/dqnp_front.sv -----
// ----------------------------------------------------------------------------
// DNS question name parser front end
// Accepts message bytes, tracks the parse phase and queues the results of
// each byte as one entry.
// ----------------------------------------------------------------------------
module dqnp_front #(
  parameter int NAME_LIMIT = dqnp_pkg::NAME_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  dqnp_in_if.sink           in_if,
  output logic              push_valid,
  output dqnp_pkg::dqnp_op_t push_op,
  input  logic              queue_full
);
  import dqnp_pkg::*;

  dqnp_phase_t phase_r, phase_nxt;
  logic [3:0]  header_count_r, header_count_nxt;
  logic [7:0]  label_remaining_r, label_remaining_nxt;
  logic        first_label_r, first_label_nxt;
  logic [7:0]  type_high_r, type_high_nxt;
  logic [7:0]  emitted_r, emitted_nxt;
  logic        overflow_r, overflow_nxt;

  logic        accept;
  logic        want_char;
  logic [7:0]  char_cand;
  logic        char_en;
  logic        sum_en;
  logic        sum_type_valid;
  logic [15:0] sum_type;

  assign in_if.ready = !queue_full;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    phase_nxt           = phase_r;
    header_count_nxt    = header_count_r;
    label_remaining_nxt = label_remaining_r;
    first_label_nxt     = first_label_r;
    type_high_nxt       = type_high_r;
    emitted_nxt         = emitted_r;
    overflow_nxt        = overflow_r;
    want_char           = 1'b0;
    char_cand           = in_if.msg_byte;
    char_en             = 1'b0;
    sum_en              = 1'b0;
    sum_type_valid      = 1'b0;
    sum_type            = '0;

    unique case (phase_r)
      PH_HEADER: begin
        header_count_nxt = header_count_r + 4'd1;
        if (header_count_nxt >= 4'(HEADER_BYTES)) phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        if (in_if.msg_byte == 8'd0) begin
          phase_nxt = PH_TYPE_HI;
        end else begin
          want_char           = !first_label_r;
          char_cand           = DOT_CHAR;
          first_label_nxt     = 1'b0;
          label_remaining_nxt = in_if.msg_byte;
          phase_nxt           = PH_LABEL;
        end
      end
      PH_LABEL: begin
        want_char           = 1'b1;
        label_remaining_nxt = label_remaining_r - 8'd1;
        if (label_remaining_nxt == 8'd0) phase_nxt = PH_LEN;
      end
      PH_TYPE_HI: begin
        type_high_nxt = in_if.msg_byte;
        phase_nxt     = PH_TYPE_LO;
      end
      PH_TYPE_LO: begin
        sum_en         = 1'b1;
        sum_type_valid = 1'b1;
        sum_type       = {type_high_r, in_if.msg_byte};
        phase_nxt      = PH_DONE;
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    if (want_char) begin
      if (emitted_r >= 8'(NAME_LIMIT)) begin
        overflow_nxt = 1'b1;
      end else begin
        emitted_nxt = emitted_r + 8'd1;
        char_en     = 1'b1;
      end
    end

    if (in_if.msg_last && phase_r != PH_TYPE_LO && phase_r != PH_DONE) sum_en = 1'b1;
  end

  assign push_valid             = accept && (char_en || sum_en);
  assign push_op.has_char       = char_en;
  assign push_op.name_char      = char_cand;
  assign push_op.has_sum        = sum_en;
  assign push_op.type_valid     = sum_type_valid;
  assign push_op.query_type     = sum_type;
  assign push_op.name_length    = emitted_nxt;
  assign push_op.name_truncated = overflow_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_if.msg_last)) begin
      phase_r           <= PH_HEADER;
      header_count_r    <= '0;
      label_remaining_r <= '0;
      first_label_r     <= 1'b1;
      type_high_r       <= '0;
      emitted_r         <= '0;
      overflow_r        <= 1'b0;
    end else if (accept) begin
      phase_r           <= phase_nxt;
      header_count_r    <= header_count_nxt;
      label_remaining_r <= label_remaining_nxt;
      first_label_r     <= first_label_nxt;
      type_high_r       <= type_high_nxt;
      emitted_r         <= emitted_nxt;
      overflow_r        <= overflow_nxt;
    end
  end

endmodule

// ----- rtl/dqnp_queue.sv -----
// ----------------------------------------------------------------------------
// DNS question name parser queue
// Short FIFO of result entries between the front and back ends.
// ----------------------------------------------------------------------------
module dqnp_queue #(
  parameter int DEPTH = dqnp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  dqnp_pkg::dqnp_op_t push_op,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output dqnp_pkg::dqnp_op_t head_op
);
  import dqnp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  dqnp_op_t            entries_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                do_pop;

  assign full       = count_r == CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_op    = entries_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push_valid && !do_pop) count_nxt = count_r + CNT_W'(1);
    else if (!push_valid && do_pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) entries_r[wr_ptr_r] <= push_op;
  end

endmodule

// ----- rtl/dqnp_back.sv -----
// ----------------------------------------------------------------------------
// DNS question name parser back end
// Splits each queue entry into its character and summary results and holds
// them in the output register until taken.
// ----------------------------------------------------------------------------
module dqnp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  dqnp_pkg::dqnp_op_t head_op,
  output logic               pop,
  dqnp_out_if.source         out_if
);
  import dqnp_pkg::*;

  logic        out_valid_r;
  logic        kind_r;
  logic [7:0]  name_char_r;
  logic [15:0] query_type_r;
  logic        type_valid_r;
  logic [7:0]  name_length_r;
  logic        name_truncated_r;
  logic        run_last_r;
  logic        char_done_r, char_done_nxt;

  logic slot_free;
  logic load;
  logic send_char;

  assign slot_free = !out_valid_r || out_if.ready;
  assign load      = slot_free && head_valid;
  assign send_char = head_op.has_char && !char_done_r;
  assign pop       = load && (!send_char || !head_op.has_sum);

  always_comb begin
    char_done_nxt = char_done_r;
    if (load) char_done_nxt = send_char && head_op.has_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      char_done_r <= 1'b0;
    end else begin
      if (slot_free) out_valid_r <= head_valid;
      char_done_r <= char_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (send_char) begin
        kind_r           <= KIND_CHAR;
        name_char_r      <= head_op.name_char;
        query_type_r     <= '0;
        type_valid_r     <= 1'b0;
        name_length_r    <= '0;
        name_truncated_r <= 1'b0;
        run_last_r       <= !head_op.has_sum;
      end else begin
        kind_r           <= KIND_SUMMARY;
        name_char_r      <= '0;
        query_type_r     <= head_op.query_type;
        type_valid_r     <= head_op.type_valid;
        name_length_r    <= head_op.name_length;
        name_truncated_r <= head_op.name_truncated;
        run_last_r       <= 1'b1;
      end
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.kind           = kind_r;
  assign out_if.name_char      = name_char_r;
  assign out_if.query_type     = query_type_r;
  assign out_if.type_valid     = type_valid_r;
  assign out_if.name_length    = name_length_r;
  assign out_if.name_truncated = name_truncated_r;
  assign out_if.run_last       = run_last_r;

endmodule

// ----- rtl/dns_question_name_parser.sv -----
// ----------------------------------------------------------------------------
// DNS question name parser
// Feed one message byte per beat on in_if with msg_last on the final byte.
// The 12-byte header is skipped, the first question name is emitted on
// out_if one character per beat (dots between labels), then one summary
// beat carries the query type, type_valid, name length and truncation flag.
// A message that ends before both type bytes gets a summary with
// type_valid low on its final byte; trailing bytes give no beats.
// run_last marks the last beat caused by an input byte.
// A result is held in the queue and then in the output register before it is shown.
// Throughput: one byte per cycle while the queue has room; a byte that gives
// a character and a summary beat is absorbed by the QUEUE_DEPTH-entry queue.
// Reset clears the parse state, the queue and the output register.
// When out_if stalls the output register holds; once the queue is full
// in_if.ready drops until the back end pops an entry.
// ----------------------------------------------------------------------------
module dns_question_name_parser #(
  parameter int NAME_LIMIT  = dqnp_pkg::NAME_LIMIT_DEF,
  parameter int QUEUE_DEPTH = dqnp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dqnp_in_if.sink    in_if,
  dqnp_out_if.source out_if
);
  import dqnp_pkg::*;

  logic     push_valid;
  dqnp_op_t push_op;
  logic     queue_full;
  logic     pop;
  logic     head_valid;
  dqnp_op_t head_op;

  dqnp_front #(
    .NAME_LIMIT(NAME_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .push_valid (push_valid),
    .push_op    (push_op),
    .queue_full (queue_full)
  );

  dqnp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_op    (push_op),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  dqnp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_if     (out_if)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !queue_full)
    else $error("queue written while full");

  a_summary_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.kind == KIND_SUMMARY |-> out_if.run_last)
    else $error("summary beat without run_last");

  a_char_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.kind == KIND_CHAR |->
      !out_if.type_valid && out_if.name_length == 8'd0 && !out_if.name_truncated)
    else $error("character beat carries summary fields");

  a_invalid_type_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.kind == KIND_SUMMARY && !out_if.type_valid |->
      out_if.query_type == 16'd0)
    else $error("query type set without type_valid");

  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

// ----- verif/dns_question_name_parser_tb.sv -----
// ----------------------------------------------------------------------------
// DNS question name parser testbench
// Streams DNS messages through the parser: edge bytes, names at and past the
// character limit, then random well-formed, cut short and noise messages.
// Every accepted byte updates a local parse model whose expected beats are
// compared field by field with the result channel, under random idling on
// both the byte and the result side.
// ----------------------------------------------------------------------------
module dns_question_name_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dqnp_pkg::*;

  localparam int NAME_LIMIT   = NAME_LIMIT_DEF;
  localparam int RANDOM_BYTES = 200;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_char;
    logic [15:0] query_type;
    logic        type_valid;
    logic [7:0]  name_length;
    logic        name_truncated;
    logic        run_last;
  } parse_result_t;

  logic clk;
  logic rst_n;

  dqnp_in_if  in_if ();
  dqnp_out_if out_if ();

  dns_question_name_parser #(
    .NAME_LIMIT(NAME_LIMIT)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  dqnp_phase_t   parse_phase;
  int            header_seen;
  logic [7:0]    label_left;
  bit            first_label;
  logic [7:0]    type_hi;
  int            name_count;
  bit            name_overflow;
  parse_result_t beat_results[$];
  parse_result_t pending_results[$];
  logic [7:0]    msg_bytes[$];
  int            error_count;
  int            bytes_sent;
  int            in_calm;
  int            out_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[dns_question_name_parser] ERROR");
    $finish;
  end

  function automatic void clear_parse_state();
    parse_phase   = PH_HEADER;
    header_seen   = 0;
    label_left    = 8'd0;
    first_label   = 1'b1;
    type_hi       = 8'd0;
    name_count    = 0;
    name_overflow = 1'b0;
  endfunction

  function automatic void emit_name_char(logic [7:0] c);
    parse_result_t r;
    if (name_count >= NAME_LIMIT) begin
      name_overflow = 1'b1;
      return;
    end
    name_count++;
    r           = '0;
    r.kind      = KIND_CHAR;
    r.name_char = c;
    beat_results.push_back(r);
  endfunction

  function automatic void emit_summary(bit type_ok, logic [15:0] qtype);
    parse_result_t r;
    r                = '0;
    r.kind           = KIND_SUMMARY;
    r.query_type     = type_ok ? qtype : 16'd0;
    r.type_valid     = type_ok;
    r.name_length    = name_count[7:0];
    r.name_truncated = name_overflow;
    beat_results.push_back(r);
  endfunction

  function automatic void parse_msg_byte(logic [7:0] b, bit last);
    bit summarized;
    summarized = 1'b0;
    beat_results.delete();
    case (parse_phase)
      PH_HEADER: begin
        header_seen++;
        if (header_seen >= HEADER_BYTES) parse_phase = PH_LEN;
      end
      PH_LEN: begin
        if (b == 8'd0) begin
          parse_phase = PH_TYPE_HI;
        end else begin
          if (!first_label) emit_name_char(DOT_CHAR);
          first_label = 1'b0;
          label_left  = b;
          parse_phase = PH_LABEL;
        end
      end
      PH_LABEL: begin
        emit_name_char(b);
        label_left--;
        if (label_left == 8'd0) parse_phase = PH_LEN;
      end
      PH_TYPE_HI: begin
        type_hi     = b;
        parse_phase = PH_TYPE_LO;
      end
      PH_TYPE_LO: begin
        emit_summary(1'b1, {type_hi, b});
        summarized  = 1'b1;
        parse_phase = PH_DONE;
      end
      default: begin
        summarized = 1'b1;
      end
    endcase
    if (last) begin
      if (!summarized && parse_phase != PH_DONE) emit_summary(1'b0, 16'd0);
      clear_parse_state();
    end
    if (beat_results.size() > 0) beat_results[beat_results.size() - 1].run_last = 1'b1;
    foreach (beat_results[i]) pending_results.push_back(beat_results[i]);
  endfunction

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", out_if.kind);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(out_if.kind));
        check_field("name_char", 16'(want.name_char), 16'(out_if.name_char));
        check_field("query_type", want.query_type, out_if.query_type);
        check_field("type_valid", 16'(want.type_valid), 16'(out_if.type_valid));
        check_field("name_length", 16'(want.name_length), 16'(out_if.name_length));
        check_field("name_truncated", 16'(want.name_truncated),
                    16'(out_if.name_truncated));
        check_field("run_last", 16'(want.run_last), 16'(out_if.run_last));
      end
    end
  end

  // mostly short gaps, a few long ones, now and then a calm stretch
  function automatic int draw_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 299) == 0) begin
      calm = $urandom_range(40, 200);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  initial begin
    int stall;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = draw_gap(out_calm);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_beat(input logic [7:0] b, input bit last);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.msg_byte <= b;
    in_if.msg_last <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    parse_msg_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) send_beat(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  function automatic void start_message();
    msg_bytes.delete();
    repeat (HEADER_BYTES) msg_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_label(int len);
    msg_bytes.push_back(len[7:0]);
    repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void end_name();
    msg_bytes.push_back(8'd0);
    msg_bytes.push_back(8'($urandom_range(0, 255)));
    msg_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic test_directed_edges();
    // end inside the header
    msg_bytes.delete();
    msg_bytes.push_back(8'hFF);
    send_message();
    // two one-byte labels with extreme characters, type 0xFFFF, one trailing byte
    msg_bytes.delete();
    for (int i = 0; i < HEADER_BYTES; i++) msg_bytes.push_back((i % 2) ? 8'hFF : 8'h00);
    msg_bytes.push_back(8'd1);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'd1);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'd0);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'h00);
    send_message();
  endtask

  task automatic test_name_limit();
    // exactly at the limit
    start_message();
    repeat (4) add_label(63);
    end_name();
    send_message();
    // dot and characters past the limit dropped
    start_message();
    repeat (4) add_label(63);
    add_label(5);
    end_name();
    send_message();
    // longest label length, then end after one type byte
    start_message();
    add_label(255);
    add_label(8);
    msg_bytes.push_back(8'd0);
    msg_bytes.push_back(8'($urandom_range(0, 255)));
    send_message();
  endtask

  task automatic test_random_messages();
    int target;
    int r;
    int cut;
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        msg_bytes.delete();
        repeat ($urandom_range(1, 40)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        start_message();
        repeat ($urandom_range(0, 4))
          add_label(($urandom_range(0, 99) < 3) ? $urandom_range(64, 255) : $urandom_range(1, 15));
        end_name();
        repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
        if (r < 30) begin
          cut = $urandom_range(1, msg_bytes.size());
          msg_bytes = msg_bytes[0:cut-1];
        end
      end
      send_message();
    end
  endtask

  initial begin
    in_if.valid    = 1'b0;
    in_if.msg_byte = 8'd0;
    in_if.msg_last = 1'b0;
    rst_n          = 1'b0;
    error_count    = 0;
    bytes_sent     = 0;
    in_calm        = 0;
    out_calm       = 0;
    clear_parse_state();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_name_limit();
    test_random_messages();

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[dns_question_name_parser] OK");
    end else begin
      $display("[dns_question_name_parser] ERROR");
    end
    $finish;
  end

endmodule
